// ===== hdl/pcape_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCA projection engine package
// Shared sizes, field widths and the controller state type.
// ----------------------------------------------------------------------------
package pcape_pkg;

   // Storage sizes.
   localparam int MAX_COMPONENTS = 16;
   localparam int MAX_DIMS       = 256;

   // Index and count widths derived from the storage sizes.
   localparam int CMP_W  = $clog2(MAX_COMPONENTS);
   localparam int CNT_W  = $clog2(MAX_COMPONENTS + 1);
   localparam int DIM_W  = $clog2(MAX_DIMS);
   localparam int WADR_W = CMP_W + DIM_W;
   localparam int WDEPTH = 1 << WADR_W;

   // Field and register widths.
   localparam int COMP_FIELD_W = 4;
   localparam int DIM_FIELD_W  = 8;
   localparam int VAL_W        = 16;
   localparam int PROD_W       = 32;
   localparam int ACC_W        = 40;
   localparam int PROJ_W       = 32;
   localparam int DIMS_REG_W   = 9;
   localparam int COMPS_REG_W  = 5;

   // Bus widths.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 9;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_DIMS_IN_USE       = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COMPONENTS_IN_USE = 1'd1;

   // Request kinds carried in tuser.
   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Rounding constant for the Q.26 to Q.12 rescale.
   localparam int RND_SHIFT = 14;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT_RD,
      ST_EMIT_LD
   } pcape_state_type;

endpackage : pcape_pkg
`default_nettype wire

// ===== hdl/pca_projection_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCA projection engine
// Streams sample elements through a shared multiply-accumulate against a
// weight memory and emits one rounded Q.12 projection per active component.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_*. tuser selects the kind: a weight load writes
//   one Q1.14 weight into the weight memory, a sample element (Q3.12) is
//   multiplied with the weight of every active component at the current
//   dimension and added into that component's 40-bit accumulator.
//   After the last dimension of a sample, one result per active component
//   leaves on rsp_*, in component order, with tlast on the final one.
// Operation:
//   A weight load is taken while the block is idle. A sample element makes
//   one pipelined pass of the single multiply-accumulate over the
//   accumulator memory, plus its drain; no request is taken until it is
//   through. The element that ends a sample then reads each result from
//   the accumulator memory and emits it before the block is idle again.
// Reset:
//   Accumulators read as zero, the element position is zero, and the
//   registers return to 256 dimensions and 16 components. Weights are
//   undefined until loaded. No clearing pass is needed.
// Stalls:
//   A result waits in the output register while rsp_tready is low; the
//   block keeps taking requests until it needs that register again.
// ----------------------------------------------------------------------------
module pca_projection_engine_top
   import pcape_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   // Request channel.
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // tdata: weight_component[3:0], weight_dim[11:4], weight_value[27:12],
   //        sample_value[43:28], zero fill[47:44]
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   // tuser: kind[0]
   input  wire                   req_tuser,
   // Result channel.
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // tdata: component_index[3:0], projection[35:4], zero fill[39:36]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // Configuration port.
   input  wire                   csr_we,
   input  wire  [CSR_ADDR_W-1:0] csr_addr,
   input  wire  [CSR_DATA_W-1:0] csr_wdata
);

   // Request fields.
   logic [COMP_FIELD_W-1:0] w_comp;
   logic [DIM_FIELD_W-1:0]  w_dim;
   logic signed [VAL_W-1:0] w_val;
   logic signed [VAL_W-1:0] s_val;

   assign w_comp = req_tdata[3:0];
   assign w_dim  = req_tdata[11:4];
   assign w_val  = req_tdata[27:12];
   assign s_val  = req_tdata[43:28];

   // Configuration registers.
   logic [DIMS_REG_W-1:0]  dims_ff;
   logic [COMPS_REG_W-1:0] comps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= DIMS_REG_W'(MAX_DIMS);
         comps_ff <= COMPS_REG_W'(MAX_COMPONENTS);
      end else if (csr_we) begin
         if (csr_addr == CSR_DIMS_IN_USE) begin
            dims_ff <= csr_wdata[DIMS_REG_W-1:0];
         end
         if (csr_addr == CSR_COMPONENTS_IN_USE) begin
            comps_ff <= csr_wdata[COMPS_REG_W-1:0];
         end
      end
   end

   // Effective counts: zero acts as one, large values clamp to the store size.
   logic [CNT_W-1:0]      nc_eff;
   logic [DIMS_REG_W-1:0] nd_eff;

   always_comb begin
      priority if (comps_ff == '0) begin
         nc_eff = CNT_W'(1);
      end else if (32'(comps_ff) > MAX_COMPONENTS) begin
         nc_eff = CNT_W'(MAX_COMPONENTS);
      end else begin
         nc_eff = CNT_W'(comps_ff);
      end
      priority if (dims_ff == '0) begin
         nd_eff = DIMS_REG_W'(1);
      end else if (32'(dims_ff) > MAX_DIMS) begin
         nd_eff = DIMS_REG_W'(MAX_DIMS);
      end else begin
         nd_eff = dims_ff;
      end
   end

   // Controller state and counters.
   pcape_state_type state_ff, state_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [DIM_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] x_ff, x_in;

   // Pipeline of the multiply-accumulate.
   logic                     rd_vld_ff;
   logic [CMP_W-1:0]         rd_k_ff;
   logic                     mul_vld_ff;
   logic [CMP_W-1:0]         mul_k_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  mul_acc_ff;

   // Output register.
   logic              rsp_vld_ff;
   logic [CMP_W-1:0]  rsp_comp_ff;
   logic [PROJ_W-1:0] rsp_proj_ff;
   logic              rsp_last_ff;

   // Decoded controls.
   logic req_accept;
   logic wt_we;
   logic mac_issue;
   logic emit_rd;
   logic emit_ld;
   logic pipe_empty;
   logic k_last;
   logic sample_end;
   logic out_free;

   assign req_accept = req_tvalid && req_tready;
   assign pipe_empty = !rd_vld_ff && !mul_vld_ff;
   assign k_last     = (k_ff + CNT_W'(1)) == nc_eff;
   assign sample_end = ({1'b0, pos_ff} + DIMS_REG_W'(1)) >= nd_eff;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == KIND_SAMPLE)) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = sample_end ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               state_in = k_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output decode of the controller.
   always_comb begin
      req_tready = 1'b0;
      mac_issue  = 1'b0;
      emit_rd    = 1'b0;
      emit_ld    = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_MAC:     mac_issue  = 1'b1;
         ST_DRAIN:   ;
         ST_EMIT_RD: emit_rd    = 1'b1;
         ST_EMIT_LD: emit_ld    = out_free;
         default:    ;
      endcase
   end

   assign wt_we = req_accept && (req_tuser == KIND_WEIGHT)
                  && (32'(w_comp) < MAX_COMPONENTS) && (32'(w_dim) < MAX_DIMS);

   // Counter updates.
   always_comb begin
      k_in   = k_ff;
      pos_in = pos_ff;
      x_in   = x_ff;
      if (req_accept && (req_tuser == KIND_SAMPLE)) begin
         k_in = '0;
         x_in = s_val;
      end
      if (mac_issue || emit_ld) begin
         k_in = k_ff + CNT_W'(1);
      end
      if ((state_ff == ST_DRAIN) && pipe_empty) begin
         k_in   = '0;
         pos_in = sample_end ? '0 : pos_ff + DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   // Weight memory: written by weight loads, read once per issued component.
   logic signed [VAL_W-1:0] wmem [0:WDEPTH-1];
   logic signed [VAL_W-1:0] w_rd_ff;
   logic [WADR_W-1:0]       w_wa;
   logic [WADR_W-1:0]       w_ra;

   assign w_wa = {w_comp[CMP_W-1:0], w_dim[DIM_W-1:0]};
   assign w_ra = {k_ff[CMP_W-1:0], pos_ff};

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wmem[w_wa] <= w_val;
      end
      if (mac_issue) begin
         w_rd_ff <= wmem[w_ra];
      end
   end

   // Accumulator memory with one valid bit per entry; an invalid entry reads zero.
   logic signed [ACC_W-1:0]  amem [0:MAX_COMPONENTS-1];
   logic signed [ACC_W-1:0]  a_rd_ff;
   logic                     a_rd_vld_ff;
   logic [MAX_COMPONENTS-1:0] acc_valid_ff;
   logic                     acc_re;
   logic                     acc_we;
   logic [CMP_W-1:0]         acc_ra;
   logic [CMP_W-1:0]         acc_wa;
   logic signed [ACC_W-1:0]  acc_wd;
   logic signed [ACC_W-1:0]  a_q;

   assign acc_re = mac_issue || emit_rd;
   assign acc_ra = k_ff[CMP_W-1:0];
   assign acc_we = mul_vld_ff;
   assign acc_wa = mul_k_ff;
   assign a_q    = a_rd_vld_ff ? a_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (acc_we) begin
         amem[acc_wa] <= acc_wd;
      end
      if (acc_re) begin
         a_rd_ff     <= amem[acc_ra];
         a_rd_vld_ff <= acc_valid_ff[acc_ra];
      end
   end

   // Valid bits: set by an accumulate, cleared once the entry is emitted. The
   // final result of a sample clears them all, inactive components included.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= '0;
      end else begin
         priority if (emit_ld && k_last) begin
            acc_valid_ff <= '0;
         end else if (emit_ld) begin
            acc_valid_ff[k_ff[CMP_W-1:0]] <= 1'b0;
         end else if (acc_we) begin
            acc_valid_ff[acc_wa] <= 1'b1;
         end
      end
   end

   // Stage one: the multiplier, fed by the registered memory reads.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= mac_issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_k_ff    <= k_ff[CMP_W-1:0];
      mul_k_ff   <= rd_k_ff;
      prod_ff    <= w_rd_ff * x_ff;
      mul_acc_ff <= a_q;
   end

   // Stage two: add the product and saturate to the 40-bit range.
   logic signed [ACC_W:0] sum;

   always_comb begin
      sum = {mul_acc_ff[ACC_W-1], mul_acc_ff} + (ACC_W+1)'(prod_ff);
      priority if (sum[ACC_W] == sum[ACC_W-1]) begin
         acc_wd = sum[ACC_W-1:0];
      end else if (sum[ACC_W]) begin
         acc_wd = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         acc_wd = {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   // Rescale Q.26 to Q.12 with round half up. The 40-bit accumulator shifted
   // by 14 always fits in 32 bits, so no saturation is needed.
   logic signed [ACC_W:0] rnd;
   logic signed [ACC_W:0] shifted;

   always_comb begin
      rnd     = {a_q[ACC_W-1], a_q} + (ACC_W+1)'(1 << (RND_SHIFT - 1));
      shifted = rnd >>> RND_SHIFT;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (emit_ld) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_ld) begin
         rsp_comp_ff <= k_ff[CMP_W-1:0];
         rsp_proj_ff <= shifted[PROJ_W-1:0];
         rsp_last_ff <= k_last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - PROJ_W - COMP_FIELD_W){1'b0}}, rsp_proj_ff,
                        COMP_FIELD_W'(rsp_comp_ff)};

   // Checks.
   a_acc_ports_apart: assert property (@(posedge clock) disable iff (reset)
      (acc_we && acc_re) |-> (acc_wa != acc_ra))
      else $error("accumulator read and write hit the same entry");

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      (mac_issue || emit_rd) |-> (k_ff < nc_eff))
      else $error("component counter beyond active components");

   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == KIND_SAMPLE)) |=> !req_tready)
      else $error("request taken while an element is in progress");

   a_emit_needs_space: assert property (@(posedge clock) disable iff (reset)
      emit_ld |-> (!rsp_vld_ff || rsp_tready))
      else $error("output register overwritten");

endmodule : pca_projection_engine_top
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCA projection engine testbench
// Streams weight loads and sample elements into the engine, keeps its own
// copy of the weight store, accumulators and element position, and compares
// every projection that comes out with the one predicted for it. Both sides
// idle at random. The register settings include zero, the largest values and
// values past the range, some of them changed in the middle of a sample.
// ----------------------------------------------------------------------------
module tb;
   import pcape_pkg::*;

   // Cycles to let the engine finish an element that ends no sample, or drain.
   localparam int SETTLE       = 3 * MAX_COMPONENTS + 16;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_ITEMS = 260;
   localparam longint ACC_HI   = (64'sd1 <<< (ACC_W - 1)) - 1;
   localparam longint ACC_LO   = -(64'sd1 <<< (ACC_W - 1));

   typedef struct {
      logic                     kind;
      logic [COMP_FIELD_W-1:0]  w_comp;
      logic [DIM_FIELD_W-1:0]   w_dim;
      logic signed [VAL_W-1:0]  w_val;
      logic signed [VAL_W-1:0]  s_val;
   } pca_request_type;

   typedef struct {
      logic [COMP_FIELD_W-1:0]  comp;
      logic signed [PROJ_W-1:0] proj;
      logic                     last;
   } projection_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = KIND_WEIGHT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_DIMS_IN_USE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predicted engine state.
   logic signed [VAL_W-1:0] weight_mem [MAX_COMPONENTS][MAX_DIMS];
   longint                  acc_bank [MAX_COMPONENTS];
   int unsigned             elem_pos = 0;
   int unsigned             dims_reg = MAX_DIMS;
   int unsigned             comps_reg = MAX_COMPONENTS;
   projection_type          proj_expected [$];

   // Stimulus bookkeeping: which weights are loaded and where the next
   // queued element will land.
   bit                      loaded [MAX_COMPONENTS][MAX_DIMS];
   int unsigned             plan_pos = 0;
   pca_request_type         req_backlog [$];
   pca_request_type         req_cur;
   int unsigned             req_gap_left = 0;
   int unsigned             rsp_stall_left = 0;
   bit                      tx_idle_on = 1'b1;
   bit                      rx_idle_on = 1'b1;
   bit                      long_hold_req = 1'b0;
   logic                    rsp_blocked = 1'b0;

   int unsigned             queued_count = 0;
   int unsigned             weight_loads_done = 0;
   int unsigned             elements_done = 0;
   int unsigned             results_seen = 0;
   int unsigned             settings_count = 0;
   int unsigned             fail_count = 0;

   pca_projection_engine_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Register values as the engine applies them.
   function automatic int unsigned eff_dims();
      if (dims_reg == 0) return 1;
      if (dims_reg > MAX_DIMS) return MAX_DIMS;
      return dims_reg;
   endfunction

   function automatic int unsigned eff_comps();
      if (comps_reg == 0) return 1;
      if (comps_reg > MAX_COMPONENTS) return MAX_COMPONENTS;
      return comps_reg;
   endfunction

   // Mostly no gap, sometimes a few cycles, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // A 16-bit value with the extremes favored.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Apply one accepted request to the predicted state and queue the
   // projections it releases.
   task automatic project_request(input pca_request_type r);
      int unsigned    nc, nd, k;
      longint         s, q;
      projection_type p;
      if (r.kind == KIND_WEIGHT) begin
         weight_mem[r.w_comp][r.w_dim] = r.w_val;
      end else begin
         nc = eff_comps();
         nd = eff_dims();
         if (elem_pos < MAX_DIMS) begin
            for (k = 0; k < nc; k++) begin
               s = acc_bank[k] + longint'($signed(weight_mem[k][elem_pos]))
                               * longint'($signed(r.s_val));
               if (s > ACC_HI) s = ACC_HI;
               if (s < ACC_LO) s = ACC_LO;
               acc_bank[k] = s;
            end
         end
         elem_pos++;
         if (elem_pos >= nd) begin
            for (k = 0; k < nc; k++) begin
               // Round to nearest, ties toward +infinity, then saturate.
               q = (acc_bank[k] + 64'sd8192) >>> RND_SHIFT;
               if (q > 64'sd2147483647) q = 64'sd2147483647;
               if (q < -64'sd2147483648) q = -64'sd2147483648;
               p.comp = k[COMP_FIELD_W-1:0];
               p.proj = q[PROJ_W-1:0];
               p.last = (k + 1 == nc);
               proj_expected.push_back(p);
            end
            // Every accumulator starts over, inactive ones too.
            for (k = 0; k < MAX_COMPONENTS; k++) acc_bank[k] = 0;
            elem_pos = 0;
         end
      end
   endtask

   task automatic push_weight(input int unsigned c, input int unsigned d,
                              input logic [VAL_W-1:0] v);
      pca_request_type r;
      r.kind   = KIND_WEIGHT;
      r.w_comp = c[COMP_FIELD_W-1:0];
      r.w_dim  = d[DIM_FIELD_W-1:0];
      r.w_val  = v;
      r.s_val  = VAL_W'($urandom);
      loaded[c][d] = 1'b1;
      req_backlog.push_back(r);
      queued_count++;
   endtask

   // Queue one sample element, loading any weight it would read that has
   // never been written.
   task automatic push_sample(input logic [VAL_W-1:0] x);
      pca_request_type r;
      int unsigned     k;
      for (k = 0; k < eff_comps(); k++)
         if (!loaded[k][plan_pos]) push_weight(k, plan_pos, pick_value());
      r.kind   = KIND_SAMPLE;
      r.w_comp = COMP_FIELD_W'($urandom);
      r.w_dim  = DIM_FIELD_W'($urandom);
      r.w_val  = VAL_W'($urandom);
      r.s_val  = x;
      req_backlog.push_back(r);
      queued_count++;
      plan_pos++;
      if (plan_pos >= eff_dims()) plan_pos = 0;
   endtask

   task automatic set_reg(input logic [CSR_ADDR_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_DIMS_IN_USE) dims_reg = val & 32'h1FF;
      else comps_reg = val & 32'h1F;
      settings_count++;
   endtask

   // Wait until every request is taken and every projection has come back,
   // then give an element that ends no sample time to finish. The check is
   // repeated after the settling time, since the last request may have left
   // the backlog at the very edge that was looked at.
   task automatic wait_idle();
      do begin
         while (req_backlog.size() != 0 || req_tvalid || proj_expected.size() != 0)
            @(posedge clock);
         repeat (SETTLE) @(posedge clock);
      end while (req_backlog.size() != 0 || req_tvalid || proj_expected.size() != 0);
   endtask

   // Request driver: presents queued requests with random gaps.
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid   <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            project_request(req_cur);
            if (req_cur.kind == KIND_WEIGHT) weight_loads_done++;
            else elements_done++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_cur = req_backlog.pop_front();
               req_tdata <= {4'b0, req_cur.s_val, req_cur.w_val,
                             req_cur.w_dim, req_cur.w_comp};
               req_tuser  <= req_cur.kind;
               req_tvalid <= 1'b1;
               req_gap_left = tx_idle_on ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each projection and stalls at random.
   always @(posedge clock) begin : rsp_monitor
      projection_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.comp = rsp_tdata[3:0];
         seen.proj = rsp_tdata[35:4];
         seen.last = rsp_tlast;
         results_seen++;
         if (proj_expected.size() == 0) begin
            $error("unexpected projection: component_index %0d, projection %0d",
                   seen.comp, seen.proj);
            fail_count++;
         end else begin
            want = proj_expected.pop_front();
            if (seen.comp !== want.comp) begin
               $error("component_index: expected %0d, got %0d", want.comp, seen.comp);
               fail_count++;
            end
            if (seen.proj !== want.proj) begin
               $error("projection: expected %0d, got %0d", want.proj, seen.proj);
               fail_count++;
            end
            if (seen.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, seen.last);
               fail_count++;
            end
         end
      end
      if (reset || rsp_blocked) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall_left = pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // One long receiver hold-off, so the engine fills up and stalls its input.
   initial begin : rsp_long_hold
      wait (long_hold_req);
      @(posedge clock);
      rsp_blocked <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_blocked <= 1'b0;
   end

   // Stimulus: directed cases, a dimension count past the range, the
   // hold-off, then random phases.
   initial begin : stimulus
      int unsigned target, phase_len, dv, cv, i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and rounding ties on two dimensions, two components.
      set_reg(CSR_DIMS_IN_USE, 2);
      set_reg(CSR_COMPONENTS_IN_USE, 2);
      push_weight(0, 0, 16'h7FFF);
      push_weight(0, 1, 16'h8000);
      push_weight(1, 0, 16'h0001);
      push_weight(1, 1, 16'hFFFF);
      push_weight(MAX_COMPONENTS - 1, MAX_DIMS - 1, 16'h8000);
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(16'h2000);
      push_sample(16'h0000);
      push_sample(16'hE000);
      push_sample(16'h0000);
      push_sample(16'h8000);
      push_sample(16'h7FFF);
      push_weight(1, 0, 16'h8000);
      push_sample(16'h0005);
      wait_idle();

      // Dimension count lowered in mid-sample: the next element ends it.
      set_reg(CSR_DIMS_IN_USE, 1);
      push_sample(16'h0007);
      wait_idle();

      // Zero in both registers acts as one.
      set_reg(CSR_DIMS_IN_USE, 0);
      set_reg(CSR_COMPONENTS_IN_USE, 0);
      push_sample(16'hFFFF);
      push_sample(16'h7FFF);
      wait_idle();

      // A dimension count past the range acts as the maximum; it is then
      // lowered below the position already reached, so the next element
      // ends the sample.
      set_reg(CSR_DIMS_IN_USE, 511);
      set_reg(CSR_COMPONENTS_IN_USE, 1);
      for (i = 0; i < 6; i++) push_sample(pick_value());
      wait_idle();
      set_reg(CSR_DIMS_IN_USE, 3);
      push_sample(pick_value());
      wait_idle();

      // Receiver holds off while the sender streams short samples.
      set_reg(CSR_DIMS_IN_USE, 1);
      set_reg(CSR_COMPONENTS_IN_USE, $urandom_range(1, 3));
      tx_idle_on = 1'b0;
      long_hold_req = 1'b1;
      for (i = 0; i < 40; i++) push_sample(pick_value());
      wait_idle();

      // Random phases, each with its own settings and idling.
      target = queued_count + RANDOM_ITEMS;
      while (queued_count < target) begin
         case ($urandom_range(0, 7))
            0: dv = 0;
            1: dv = $urandom_range(9, 20);
            default: dv = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 7))
            0: cv = 0;
            1: cv = $urandom_range(MAX_COMPONENTS + 1, 31);
            2: cv = MAX_COMPONENTS;
            default: cv = $urandom_range(1, MAX_COMPONENTS - 1);
         endcase
         if ($urandom_range(0, 3) != 0) set_reg(CSR_DIMS_IN_USE, dv);
         if ($urandom_range(0, 3) != 0) set_reg(CSR_COMPONENTS_IN_USE, cv);
         tx_idle_on = ($urandom_range(0, 4) != 0);
         rx_idle_on = ($urandom_range(0, 4) != 0);
         phase_len = $urandom_range(15, 45);
         for (i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 4) == 0)
               push_weight($urandom_range(0, MAX_COMPONENTS - 1),
                           $urandom_range(0, MAX_DIMS - 1), pick_value());
            else
               push_sample(pick_value());
         end
         wait_idle();
      end

      // Any projection still owed at this point is missing.
      if (proj_expected.size() != 0) begin
         $error("projection: expected %0d more, got none", proj_expected.size());
         fail_count++;
      end

      $display("Run covered %0d requests: %0d weight loads and %0d sample elements.",
               weight_loads_done + elements_done, weight_loads_done, elements_done);
      $display("Checked %0d projections under %0d register writes, %0d mismatches.",
               results_seen, settings_count, fail_count);
      if (fail_count == 0) begin
         $display("** pca_projection_engine_top: PASSED **");
      end else begin
         $display("** pca_projection_engine_top: FAILED **");
      end
      $finish;
   end

   // Watchdog against a hung engine.
   initial begin : watchdog
      #40_000_000;
      $display("Timeout: %0d projections still expected.", proj_expected.size());
      $display("** pca_projection_engine_top: FAILED **");
      $finish;
   end

endmodule

// ===== pca_projection_engine_top.f =====
hdl/pcape_pkg.sv
hdl/pca_projection_engine_top.sv
test/tb.sv
